>>> hdl/zse_pkg.sv
package zse_pkg;

   // Opcodes of the supported subset
   localparam logic [7:0] OP_NOP      = 8'h00;
   localparam logic [7:0] OP_LD_BC_NN = 8'h01;
   localparam logic [7:0] OP_LD_BCI_A = 8'h02;
   localparam logic [7:0] OP_INC_BC   = 8'h03;
   localparam logic [7:0] OP_INC_B    = 8'h04;
   localparam logic [7:0] OP_DEC_B    = 8'h05;
   localparam logic [7:0] OP_RLCA     = 8'h07;
   localparam logic [7:0] OP_EX_AF    = 8'h08;
   localparam logic [7:0] OP_ADD_HLBC = 8'h09;
   localparam logic [7:0] OP_LD_A_BCI = 8'h0A;
   localparam logic [7:0] OP_DEC_BC   = 8'h0B;
   localparam logic [7:0] OP_INC_C    = 8'h0C;
   localparam logic [7:0] OP_DEC_C    = 8'h0D;
   localparam logic [7:0] OP_LD_DE_NN = 8'h11;
   localparam logic [7:0] OP_LD_DEI_A = 8'h12;
   localparam logic [7:0] OP_LD_A_DEI = 8'h1A;
   localparam logic [7:0] OP_LD_HL_NN = 8'h21;
   localparam logic [7:0] OP_LD_HL_MM = 8'h2A;
   localparam logic [7:0] OP_LD_SP_NN = 8'h31;
   localparam logic [7:0] OP_LD_MM_A  = 8'h32;
   localparam logic [7:0] OP_LD_M_N   = 8'h36;
   localparam logic [7:0] OP_LD_A_MM  = 8'h3A;
   localparam logic [7:0] OP_HALT     = 8'h76;
   localparam logic [7:0] OP_EXX      = 8'hD9;
   localparam logic [7:0] OP_PFX_IX   = 8'hDD;
   localparam logic [7:0] OP_EX_SP    = 8'hE3;
   localparam logic [7:0] OP_EX_DEHL  = 8'hEB;
   localparam logic [7:0] OP_PFX_IY   = 8'hFD;

   // Opcode group masks and patterns
   localparam logic [7:0] GRP_MASK    = 8'hC7;
   localparam logic [7:0] GRP_LD_R_N  = 8'h06;
   localparam logic [7:0] GRP_LD_R_M  = 8'h46;
   localparam logic [2:0] R_MEM       = 3'd6;
   localparam logic [2:0] R_B         = 3'd0;
   localparam logic [2:0] R_C         = 3'd1;

   // Controller to datapath commands
   typedef struct packed {
      logic clr_wr;
      logic host_wr;
      logic start;
      logic fetch_rd;
      logic fetch_cap;
      logic data_rd;
      logic data_cap;
      logic data_wr;
      logic exec;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clr_last;
      logic fetch_more;
      logic need_rd;
      logic need_wr;
      logic rd_more;
      logic wr_more;
   } stat_type;

endpackage

>>> hdl/zse_ctrl.sv
module zse_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_op,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  zse_pkg::stat_type  st,
   output zse_pkg::cmd_type   cmd
);

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_FETCH = 10'b0000000100,
      S_FCAP  = 10'b0000001000,
      S_DISP  = 10'b0000010000,
      S_RD    = 10'b0000100000,
      S_RCAP  = 10'b0001000000,
      S_WR    = 10'b0010000000,
      S_EXEC  = 10'b0100000000,
      S_RESP  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (st.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               if (req_op) begin
                  cmd.start = 1'b1;
                  state_in  = S_FETCH;
               end else begin
                  cmd.host_wr = 1'b1;
                  state_in    = S_RESP;
               end
            end
         end
         S_FETCH: begin
            cmd.fetch_rd = 1'b1;
            state_in     = S_FCAP;
         end
         S_FCAP: begin
            cmd.fetch_cap = 1'b1;
            state_in      = st.fetch_more ? S_FETCH : S_DISP;
         end
         S_DISP: begin
            if (st.need_rd)      state_in = S_RD;
            else if (st.need_wr) state_in = S_WR;
            else                 state_in = S_EXEC;
         end
         S_RD: begin
            cmd.data_rd = 1'b1;
            state_in    = S_RCAP;
         end
         S_RCAP: begin
            cmd.data_cap = 1'b1;
            if (st.rd_more)      state_in = S_RD;
            else if (st.need_wr) state_in = S_WR;
            else                 state_in = S_EXEC;
         end
         S_WR: begin
            cmd.data_wr = 1'b1;
            if (!st.wr_more) state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

>>> hdl/zse_dpath.sv
module zse_dpath #(
   parameter int MEM_DEPTH = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  zse_pkg::cmd_type   cmd,
   output zse_pkg::stat_type  st,
   input  logic [15:0]        req_mem_addr,
   input  logic [7:0]         req_mem_data,
   output logic               status,
   output logic [15:0]        pc,
   output logic [7:0]         acc,
   output logic [5:0]         flags,
   output logic [15:0]        bc,
   output logic [15:0]        de,
   output logic [15:0]        hl,
   output logic [15:0]        sp,
   output logic [15:0]        ix,
   output logic [15:0]        iy
);

   localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int CW = $clog2(MEM_DEPTH + 1);

   // Address reduction: eight compare/subtract steps, quotient stays below 256
   function automatic logic [AW-1:0] mem_index(input logic [15:0] a);
      logic [23:0] r;
      logic [23:0] d;
      r = {8'd0, a};
      for (int k = 7; k >= 0; k--) begin
         d = 24'(MEM_DEPTH) << k;
         if (r >= d) r = r - d;
      end
      return r[AW-1:0];
   endfunction

   // Instruction length in bytes from opcode and second byte
   function automatic logic [2:0] instr_len(input logic [7:0] b0, input logic [7:0] b1);
      logic [2:0] n;
      n = 3'd1;
      if (b0 == zse_pkg::OP_PFX_IX || b0 == zse_pkg::OP_PFX_IY) begin
         n = 3'd2;
         if (((b1 & zse_pkg::GRP_MASK) == zse_pkg::GRP_LD_R_M && b1 != zse_pkg::OP_HALT) ||
             (b1[7:3] == 5'b01110 && b1 != zse_pkg::OP_HALT))
            n = 3'd3;
         else if (b1 == zse_pkg::OP_LD_M_N || b1 == zse_pkg::OP_LD_HL_NN)
            n = 3'd4;
      end else if ((b0 & zse_pkg::GRP_MASK) == zse_pkg::GRP_LD_R_N) begin
         n = 3'd2;
      end else if (b0 == zse_pkg::OP_LD_BC_NN || b0 == zse_pkg::OP_LD_DE_NN ||
                   b0 == zse_pkg::OP_LD_HL_NN || b0 == zse_pkg::OP_LD_SP_NN ||
                   b0 == zse_pkg::OP_LD_A_MM || b0 == zse_pkg::OP_LD_MM_A ||
                   b0 == zse_pkg::OP_LD_HL_MM) begin
         n = 3'd3;
      end
      return n;
   endfunction

   logic [7:0]  mem [MEM_DEPTH];
   logic [7:0]  rd_ff;
   logic [CW-1:0] clr_ff;
   logic [7:0]  ib_ff [4];
   logic [7:0]  rb_ff [2];
   logic [2:0]  cnt_ff;
   logic        rcnt_ff, wcnt_ff;
   logic        status_ff;
   logic [15:0] pc_ff, bc_ff, de_ff, hl_ff, sp_ff, ix_ff, iy_ff;
   logic [15:0] bcs_ff, des_ff, hls_ff;
   logic [13:0] afs_ff;
   logic [7:0]  a_ff;
   logic [5:0]  f_ff;

   // Register-only 8-bit source
   function automatic logic [7:0] reg8(input logic [2:0] code, input logic [7:0] a,
                                       input logic [15:0] b, input logic [15:0] d,
                                       input logic [15:0] h);
      logic [7:0] v;
      case (code)
         3'd0:    v = b[15:8];
         3'd1:    v = b[7:0];
         3'd2:    v = d[15:8];
         3'd3:    v = d[7:0];
         3'd4:    v = h[15:8];
         3'd5:    v = h[7:0];
         3'd7:    v = a;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   // Fetch progress, looking at the byte just read
   logic [7:0] v0, v1;
   assign v0 = (cnt_ff == 3'd0) ? rd_ff : ib_ff[0];
   assign v1 = (cnt_ff == 3'd1) ? rd_ff : ib_ff[1];

   // Decode of data accesses
   logic        prefix, legal, ex;
   logic [1:0]  nrd, nwr;
   logic [15:0] base, nn, imm, idx, ixa, swv;
   logic [7:0]  wval, o0, o1;

   assign o0     = ib_ff[0];
   assign o1     = ib_ff[1];
   assign prefix = (o0 == zse_pkg::OP_PFX_IX) || (o0 == zse_pkg::OP_PFX_IY);
   assign nn     = {ib_ff[2], ib_ff[1]};
   assign imm    = {ib_ff[3], ib_ff[2]};
   assign idx    = (o0 == zse_pkg::OP_PFX_IY) ? iy_ff : ix_ff;
   assign ixa    = idx + {{8{ib_ff[2][7]}}, ib_ff[2]};
   assign swv    = prefix ? idx : hl_ff;

   always_comb begin
      legal = 1'b0;
      nrd   = 2'd0;
      nwr   = 2'd0;
      base  = hl_ff;
      wval  = 8'h00;
      ex    = 1'b0;
      if (!prefix) begin
         if (o0[7:6] == 2'b01) begin
            if (o0 != zse_pkg::OP_HALT) begin
               legal = 1'b1;
               if (o0[2:0] == zse_pkg::R_MEM) nrd = 2'd1;
               if (o0[5:3] == zse_pkg::R_MEM) begin
                  nwr  = 2'd1;
                  wval = reg8(o0[2:0], a_ff, bc_ff, de_ff, hl_ff);
               end
            end
         end else if (o0[7:3] == 5'b10000) begin
            legal = 1'b1;
            if (o0[2:0] == zse_pkg::R_MEM) nrd = 2'd1;
         end else if ((o0 & zse_pkg::GRP_MASK) == zse_pkg::GRP_LD_R_N) begin
            legal = 1'b1;
            if (o0[5:3] == zse_pkg::R_MEM) begin
               nwr  = 2'd1;
               wval = ib_ff[1];
            end
         end else begin
            unique case (o0) inside
               zse_pkg::OP_NOP, zse_pkg::OP_LD_BC_NN, zse_pkg::OP_LD_DE_NN,
               zse_pkg::OP_LD_HL_NN, zse_pkg::OP_LD_SP_NN, zse_pkg::OP_INC_BC,
               zse_pkg::OP_DEC_BC, zse_pkg::OP_INC_B, zse_pkg::OP_DEC_B,
               zse_pkg::OP_INC_C, zse_pkg::OP_DEC_C, zse_pkg::OP_RLCA,
               zse_pkg::OP_ADD_HLBC, zse_pkg::OP_EX_DEHL, zse_pkg::OP_EX_AF,
               zse_pkg::OP_EXX: legal = 1'b1;
               zse_pkg::OP_LD_A_BCI: begin legal = 1'b1; nrd = 2'd1; base = bc_ff; end
               zse_pkg::OP_LD_A_DEI: begin legal = 1'b1; nrd = 2'd1; base = de_ff; end
               zse_pkg::OP_LD_A_MM:  begin legal = 1'b1; nrd = 2'd1; base = nn; end
               zse_pkg::OP_LD_HL_MM: begin legal = 1'b1; nrd = 2'd2; base = nn; end
               zse_pkg::OP_LD_BCI_A: begin
                  legal = 1'b1; nwr = 2'd1; base = bc_ff; wval = a_ff;
               end
               zse_pkg::OP_LD_DEI_A: begin
                  legal = 1'b1; nwr = 2'd1; base = de_ff; wval = a_ff;
               end
               zse_pkg::OP_LD_MM_A: begin
                  legal = 1'b1; nwr = 2'd1; base = nn; wval = a_ff;
               end
               zse_pkg::OP_EX_SP: begin
                  legal = 1'b1; nrd = 2'd2; nwr = 2'd2; base = sp_ff; ex = 1'b1;
               end
               default: legal = 1'b0;
            endcase
         end
      end else begin
         if ((o1 & zse_pkg::GRP_MASK) == zse_pkg::GRP_LD_R_M && o1 != zse_pkg::OP_HALT) begin
            legal = 1'b1; nrd = 2'd1; base = ixa;
         end else if (o1[7:3] == 5'b01110 && o1 != zse_pkg::OP_HALT) begin
            legal = 1'b1; nwr = 2'd1; base = ixa;
            wval  = reg8(o1[2:0], a_ff, bc_ff, de_ff, hl_ff);
         end else if (o1 == zse_pkg::OP_LD_M_N) begin
            legal = 1'b1; nwr = 2'd1; base = ixa; wval = ib_ff[3];
         end else if (o1 == zse_pkg::OP_LD_HL_NN) begin
            legal = 1'b1;
         end else if (o1 == zse_pkg::OP_EX_SP) begin
            legal = 1'b1; nrd = 2'd2; nwr = 2'd2; base = sp_ff; ex = 1'b1;
         end
      end
   end

   // Status toward the controller
   assign st.clr_last   = (clr_ff == CW'(MEM_DEPTH - 1));
   assign st.fetch_more = (3'(cnt_ff + 3'd1) < instr_len(v0, v1));
   assign st.need_rd    = (nrd != 2'd0);
   assign st.need_wr    = (nwr != 2'd0);
   assign st.rd_more    = !rcnt_ff && (nrd == 2'd2);
   assign st.wr_more    = !wcnt_ff && (nwr == 2'd2);

   // Memory port selection
   logic [7:0]    wdata;
   logic [AW-1:0] widx, ridx;
   logic          we;

   always_comb begin
      we    = cmd.clr_wr | cmd.host_wr | cmd.data_wr;
      widx  = mem_index(16'(base + {15'd0, wcnt_ff}));
      wdata = ex ? (wcnt_ff ? swv[15:8] : swv[7:0]) : wval;
      if (cmd.clr_wr) begin
         widx  = clr_ff[AW-1:0];
         wdata = 8'h00;
      end else if (cmd.host_wr) begin
         widx  = mem_index(req_mem_addr);
         wdata = req_mem_data;
      end
      ridx = cmd.fetch_rd ? mem_index(pc_ff) : mem_index(16'(base + {15'd0, rcnt_ff}));
   end

   always_ff @(posedge clock) begin
      if (we) mem[widx] <= wdata;
      rd_ff <= mem[ridx];
   end

   // Clear sweep counter
   always_ff @(posedge clock) begin
      if (reset)           clr_ff <= '0;
      else if (cmd.clr_wr) clr_ff <= CW'(clr_ff + 1'b1);
   end

   // Fetch and operand byte capture
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         rcnt_ff <= 1'b0;
         wcnt_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            cnt_ff  <= '0;
            rcnt_ff <= 1'b0;
            wcnt_ff <= 1'b0;
         end
         if (cmd.fetch_cap) cnt_ff  <= 3'(cnt_ff + 3'd1);
         if (cmd.data_cap)  rcnt_ff <= 1'b1;
         if (cmd.data_wr)   wcnt_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch_cap) ib_ff[cnt_ff[1:0]] <= rd_ff;
      if (cmd.data_cap)  rb_ff[rcnt_ff]     <= rd_ff;
   end

   // Instruction execution: next register values
   logic [7:0]  a_in;
   logic [5:0]  f_in;
   logic [15:0] bc_in, de_in, hl_in, sp_in, ix_in, iy_in, bcs_in, des_in, hls_in;
   logic [13:0] afs_in;
   logic        ld_en;
   logic [2:0]  ld_code;
   logic [7:0]  ld_val, addv, addr_res;
   logic [8:0]  sum9;
   logic [4:0]  hsum;
   logic [16:0] sum17;
   logic [12:0] hsum12;
   logic [15:0] rbw;

   assign rbw = {rb_ff[1], rb_ff[0]};

   always_comb begin
      a_in   = a_ff;   f_in   = f_ff;
      bc_in  = bc_ff;  de_in  = de_ff;  hl_in  = hl_ff;
      sp_in  = sp_ff;  ix_in  = ix_ff;  iy_in  = iy_ff;
      bcs_in = bcs_ff; des_in = des_ff; hls_in = hls_ff; afs_in = afs_ff;
      ld_en   = 1'b0;
      ld_code = o0[5:3];
      ld_val  = (o0[2:0] == zse_pkg::R_MEM) ? rb_ff[0]
                                            : reg8(o0[2:0], a_ff, bc_ff, de_ff, hl_ff);
      addv     = ld_val;
      sum9     = {1'b0, a_ff} + {1'b0, addv};
      addr_res = sum9[7:0];
      hsum     = {1'b0, a_ff[3:0]} + {1'b0, addv[3:0]};
      sum17    = {1'b0, hl_ff} + {1'b0, bc_ff};
      hsum12   = {1'b0, hl_ff[11:0]} + {1'b0, bc_ff[11:0]};
      if (!prefix) begin
         if (o0[7:6] == 2'b01) begin
            ld_en = (o0[5:3] != zse_pkg::R_MEM);
         end else if (o0[7:3] == 5'b10000) begin
            a_in = addr_res;
            f_in = {hsum[4], 1'b0, addr_res[7],
                    (~(a_ff[7] ^ addv[7])) & (a_ff[7] ^ addr_res[7]),
                    (addr_res == 8'h00), sum9[8]};
         end else if ((o0 & zse_pkg::GRP_MASK) == zse_pkg::GRP_LD_R_N) begin
            ld_en  = (o0[5:3] != zse_pkg::R_MEM);
            ld_val = ib_ff[1];
         end else begin
            unique case (o0) inside
               zse_pkg::OP_LD_A_BCI, zse_pkg::OP_LD_A_DEI,
               zse_pkg::OP_LD_A_MM:  a_in  = rb_ff[0];
               zse_pkg::OP_LD_BC_NN: bc_in = nn;
               zse_pkg::OP_LD_DE_NN: de_in = nn;
               zse_pkg::OP_LD_HL_NN: hl_in = nn;
               zse_pkg::OP_LD_SP_NN: sp_in = nn;
               zse_pkg::OP_LD_HL_MM, zse_pkg::OP_EX_SP: hl_in = rbw;
               zse_pkg::OP_INC_BC:   bc_in = 16'(bc_ff + 16'd1);
               zse_pkg::OP_DEC_BC:   bc_in = 16'(bc_ff - 16'd1);
               zse_pkg::OP_INC_B: begin
                  ld_en = 1'b1; ld_code = zse_pkg::R_B; ld_val = 8'(bc_ff[15:8] + 8'd1);
               end
               zse_pkg::OP_DEC_B: begin
                  ld_en = 1'b1; ld_code = zse_pkg::R_B; ld_val = 8'(bc_ff[15:8] - 8'd1);
               end
               zse_pkg::OP_INC_C: begin
                  ld_en = 1'b1; ld_code = zse_pkg::R_C; ld_val = 8'(bc_ff[7:0] + 8'd1);
               end
               zse_pkg::OP_DEC_C: begin
                  ld_en = 1'b1; ld_code = zse_pkg::R_C; ld_val = 8'(bc_ff[7:0] - 8'd1);
               end
               zse_pkg::OP_RLCA: begin
                  a_in = {a_ff[6:0], a_ff[7]};
                  f_in = {2'b00, f_ff[3:1], a_ff[7]};
               end
               zse_pkg::OP_ADD_HLBC: begin
                  hl_in = sum17[15:0];
                  f_in  = {hsum12[12], 1'b0, f_ff[3:1], sum17[16]};
               end
               zse_pkg::OP_EX_DEHL: begin
                  hl_in = de_ff;
                  de_in = hl_ff;
               end
               zse_pkg::OP_EX_AF: begin
                  a_in   = afs_ff[13:6];
                  f_in   = afs_ff[5:0];
                  afs_in = {a_ff, f_ff};
               end
               zse_pkg::OP_EXX: begin
                  bc_in = bcs_ff; bcs_in = bc_ff;
                  de_in = des_ff; des_in = de_ff;
                  hl_in = hls_ff; hls_in = hl_ff;
               end
               default: ;
            endcase
         end
      end else begin
         if ((o1 & zse_pkg::GRP_MASK) == zse_pkg::GRP_LD_R_M && o1 != zse_pkg::OP_HALT) begin
            ld_en   = 1'b1;
            ld_code = o1[5:3];
            ld_val  = rb_ff[0];
         end else if (o1 == zse_pkg::OP_LD_HL_NN || o1 == zse_pkg::OP_EX_SP) begin
            if (o0 == zse_pkg::OP_PFX_IY) iy_in = (o1 == zse_pkg::OP_EX_SP) ? rbw : imm;
            else                          ix_in = (o1 == zse_pkg::OP_EX_SP) ? rbw : imm;
         end
      end
      // 8-bit register write-back
      if (ld_en) begin
         case (ld_code)
            3'd0:    bc_in = {ld_val, bc_ff[7:0]};
            3'd1:    bc_in = {bc_ff[15:8], ld_val};
            3'd2:    de_in = {ld_val, de_ff[7:0]};
            3'd3:    de_in = {de_ff[15:8], ld_val};
            3'd4:    hl_in = {ld_val, hl_ff[7:0]};
            3'd5:    hl_in = {hl_ff[15:8], ld_val};
            3'd7:    a_in  = ld_val;
            default: ;
         endcase
      end
   end

   // Architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= 1'b0;
         pc_ff  <= '0; a_ff   <= '0; f_ff   <= '0;
         bc_ff  <= '0; de_ff  <= '0; hl_ff  <= '0;
         sp_ff  <= '0; ix_ff  <= '0; iy_ff  <= '0;
         bcs_ff <= '0; des_ff <= '0; hls_ff <= '0; afs_ff <= '0;
      end else begin
         if (cmd.host_wr)   status_ff <= 1'b0;
         if (cmd.fetch_cap) pc_ff <= 16'(pc_ff + 16'd1);
         if (cmd.exec) begin
            status_ff <= !legal;
            if (legal) begin
               a_ff   <= a_in;   f_ff   <= f_in;
               bc_ff  <= bc_in;  de_ff  <= de_in;  hl_ff  <= hl_in;
               sp_ff  <= sp_in;  ix_ff  <= ix_in;  iy_ff  <= iy_in;
               bcs_ff <= bcs_in; des_ff <= des_in; hls_ff <= hls_in;
               afs_ff <= afs_in;
            end
         end
      end
   end

   assign status = status_ff;
   assign pc     = pc_ff;
   assign acc    = a_ff;
   assign flags  = f_ff;
   assign bc     = bc_ff;
   assign de     = de_ff;
   assign hl     = hl_ff;
   assign sp     = sp_ff;
   assign ix     = ix_ff;
   assign iy     = iy_ff;

endmodule

>>> hdl/z80_subset_instruction_executor_top.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_op, req_mem_addr, req_mem_data
// rsp       out        rsp_valid/rsp_stall   rsp_status and the register file
//
// A byte write passes through the accepting idle state and the response state. An instruction
// passes through the idle state, a fetch and a capture state per fetched byte (1..4), a dispatch
// state, a read and a capture state per data read, a write state per data write, an execute
// state and the response state. After reset a clearing pass zeroes the memory, one byte a cycle,
// with req_stall high. One transaction is in flight at a time; the response holds while
// rsp_stall is high and req_stall stays high until it is taken.
module z80_subset_instruction_executor_top #(
   parameter int MEM_DEPTH = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [15:0] req_mem_addr,
   input  logic [7:0]  req_mem_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [15:0] rsp_pc_out,
   output logic [7:0]  rsp_acc_out,
   output logic [5:0]  rsp_flags_out,
   output logic [15:0] rsp_bc_out,
   output logic [15:0] rsp_de_out,
   output logic [15:0] rsp_hl_out,
   output logic [15:0] rsp_sp_out,
   output logic [15:0] rsp_ix_out,
   output logic [15:0] rsp_iy_out
);

   zse_pkg::cmd_type  cmd;
   zse_pkg::stat_type st;

   // Sequencer
   zse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // Registers, memory and execution logic
   zse_dpath #(.MEM_DEPTH(MEM_DEPTH)) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .st           (st),
      .req_mem_addr (req_mem_addr),
      .req_mem_data (req_mem_data),
      .status       (rsp_status),
      .pc           (rsp_pc_out),
      .acc          (rsp_acc_out),
      .flags        (rsp_flags_out),
      .bc           (rsp_bc_out),
      .de           (rsp_de_out),
      .hl           (rsp_hl_out),
      .sp           (rsp_sp_out),
      .ix           (rsp_ix_out),
      .iy           (rsp_iy_out)
   );

endmodule
